// ===== rtl/polygon_vector_area_centroid_unit_macros.svh =====
// ---------------------------------------------------------------------------
// polygon vector area unit assertion macros
// clocked property helpers used by the checker file
// ---------------------------------------------------------------------------
`ifndef POLYGON_VECTOR_AREA_CENTROID_UNIT_MACROS_SVH
`define POLYGON_VECTOR_AREA_CENTROID_UNIT_MACROS_SVH

// property checked while out of reset
`define PVAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define PVAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pvac_pkg.sv =====
// ---------------------------------------------------------------------------
// pvac_pkg
// shared constants, types and command/status bundles of the area unit
// ---------------------------------------------------------------------------
package pvac_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int AREA_W     = 42;
    localparam int SUM_W      = AREA_W + 1;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int CSUM_W     = 27;
    localparam int MUL_STEPS  = 6;
    localparam int DIV_STEPS  = CSUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_CLOSE,
        ST_DIV,
        ST_OUT
    } t_state;

    // cross product terms in issue order
    typedef enum logic [2:0] {
        T_X_POS,
        T_X_NEG,
        T_Y_POS,
        T_Y_NEG,
        T_Z_POS,
        T_Z_NEG
    } t_term;

    typedef struct packed {
        logic  accept;
        logic  mul_en;
        t_term term;
        logic  use_first;
        logic  shift_prev;
        logic  div_start;
        logic  div_step;
        logic  clear;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic last;
    } t_status;

endpackage

// ===== rtl/polygon_vector_area_centroid_unit.sv =====
// The first vertex of a polygon is only stored; a plain vertex takes the accept plus 6 multiply steps.
// A final vertex adds 6 closing-edge multiply steps, 27 divide steps and the result beat;
// a single vertex skips the vertex multiply steps, and past the vertex limit only the result beat follows.
// No vertex is taken while the unit is busy; the next vertex is taken the cycle after the strobe.
// Synchronous active-low reset clears the sequencer, counts and sums; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
// polygon_vector_area_centroid_unit
// vector area and vertex centroid of a polygon given as a vertex stream
// ---------------------------------------------------------------------------
module polygon_vector_area_centroid_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_z,
    input  logic                                  i_last_point,
    output logic                                  o_valid,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_x,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_y,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_z,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_x,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_y,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_z,
    output logic                                  o_too_many_points
);
    import pvac_pkg::*;

    t_cmd    cmd;
    t_status status;

    pvac_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_last_point),
        .i_status     (status),
        .o_cmd        (cmd),
        .busy         (busy),
        .o_valid      (o_valid)
    );

    pvac_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_point_z         (i_point_z),
        .i_last_point      (i_last_point),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_area_x          (o_area_x),
        .o_area_y          (o_area_y),
        .o_area_z          (o_area_z),
        .o_center_x        (o_center_x),
        .o_center_y        (o_center_y),
        .o_center_z        (o_center_z),
        .o_too_many_points (o_too_many_points)
    );

endmodule

// ===== rtl/pvac_ctrl.sv =====
// ---------------------------------------------------------------------------
// pvac_ctrl
// sequencer: multiply steps per vertex, closing edge, divide, result beat
// ---------------------------------------------------------------------------
module pvac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last_point,
    input  pvac_pkg::t_status i_status,
    output pvac_pkg::t_cmd    o_cmd,
    output logic             busy,
    output logic             o_valid
);
    import pvac_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                accept;
    logic                mul_done;
    logic                div_done;

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = (r_state == ST_OUT);
    assign accept   = start && !busy;
    assign mul_done = (r_step == STEP_W'(MUL_STEPS - 1));
    assign div_done = (r_step == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (accept) begin
                    priority if (!i_status.count_zero && !i_status.count_full) begin
                        n_state = ST_CROSS;
                    end else if (!i_last_point) begin
                        n_state = ST_IDLE;
                    end else if (i_status.count_full) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_CROSS: begin
                n_step = r_step + 1'b1;
                if (mul_done) begin
                    n_step  = '0;
                    n_state = i_status.last ? ST_CLOSE : ST_IDLE;
                end
            end
            ST_CLOSE: begin
                n_step = r_step + 1'b1;
                if (mul_done) begin
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_step = r_step + 1'b1;
                if (div_done) begin
                    n_step  = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_step  = '0;
                n_state = ST_IDLE;
            end
            default: begin
                n_step  = '0;
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.term       = t_term'(r_step[2:0]);
        o_cmd.accept     = accept;
        unique case (r_state)
            ST_IDLE: ;
            ST_CROSS: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.shift_prev = mul_done;
            end
            ST_CLOSE: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.use_first  = 1'b1;
                o_cmd.div_start  = mul_done;
            end
            ST_DIV: begin
                o_cmd.div_step   = 1'b1;
            end
            ST_OUT: begin
                o_cmd.clear      = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/pvac_dp.sv =====
// ---------------------------------------------------------------------------
// pvac_dp
// vertex store, shared multiplier, cross/coordinate sums, centroid divider
// ---------------------------------------------------------------------------
module pvac_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [pvac_pkg::COORD_BITS-1:0] i_point_z,
    input  logic                                  i_last_point,
    input  pvac_pkg::t_cmd                         i_cmd,
    output pvac_pkg::t_status                      o_status,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_x,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_y,
    output logic signed [pvac_pkg::AREA_W-1:0]     o_area_z,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_x,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_y,
    output logic signed [pvac_pkg::COORD_BITS-1:0] o_center_z,
    output logic                                  o_too_many_points
);
    import pvac_pkg::*;

    logic signed [COORD_BITS-1:0] pin     [3];
    logic signed [COORD_BITS-1:0] r_first [3];
    logic signed [COORD_BITS-1:0] r_prev  [3];
    logic signed [COORD_BITS-1:0] r_cur   [3];
    logic signed [COORD_BITS-1:0] opb     [3];
    logic signed [CSUM_W-1:0]     r_csum  [3];
    logic signed [SUM_W-1:0]      r_cross [3];
    logic [CSUM_W-1:0]            r_dq    [3];
    logic [CNT_W-1:0]             r_rem   [3];
    logic                         r_neg   [3];
    logic [CNT_W:0]               shifted [3];
    logic [CNT_W:0]               trial   [3];
    logic [CSUM_W-1:0]            quo     [3];
    logic [CNT_W-1:0]             r_count;
    logic                         r_ovf;
    logic                         r_last;
    logic signed [COORD_BITS-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_prod_vld;
    t_term                        r_prod_term;
    logic                         count_zero;
    logic                         count_full;
    logic [1:0]                   acc_idx;
    logic                         acc_sub;

    assign pin[0] = i_point_x;
    assign pin[1] = i_point_y;
    assign pin[2] = i_point_z;

    assign count_zero = (r_count == '0);
    assign count_full = (r_count >= CNT_W'(MAX_POINTS));

    assign o_status.count_zero = count_zero;
    assign o_status.count_full = count_full;
    assign o_status.last       = r_last;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            opb[i] = i_cmd.use_first ? r_first[i] : r_cur[i];
        end
    end

    // operand pick for the shared multiplier
    always_comb begin
        unique case (i_cmd.term)
            T_X_POS: begin mul_a = r_prev[1]; mul_b = opb[2]; end
            T_X_NEG: begin mul_a = r_prev[2]; mul_b = opb[1]; end
            T_Y_POS: begin mul_a = r_prev[2]; mul_b = opb[0]; end
            T_Y_NEG: begin mul_a = r_prev[0]; mul_b = opb[2]; end
            T_Z_POS: begin mul_a = r_prev[0]; mul_b = opb[1]; end
            T_Z_NEG: begin mul_a = r_prev[1]; mul_b = opb[0]; end
            default: begin mul_a = '0;        mul_b = '0;     end
        endcase
    end

    always_comb begin
        unique case (r_prod_term)
            T_X_POS: begin acc_idx = 2'd0; acc_sub = 1'b0; end
            T_X_NEG: begin acc_idx = 2'd0; acc_sub = 1'b1; end
            T_Y_POS: begin acc_idx = 2'd1; acc_sub = 1'b0; end
            T_Y_NEG: begin acc_idx = 2'd1; acc_sub = 1'b1; end
            T_Z_POS: begin acc_idx = 2'd2; acc_sub = 1'b0; end
            T_Z_NEG: begin acc_idx = 2'd2; acc_sub = 1'b1; end
            default: begin acc_idx = 2'd0; acc_sub = 1'b0; end
        endcase
    end

    // restoring divide step, one quotient bit per lane per cycle while div_step is set
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = {r_rem[i], r_dq[i][CSUM_W-1]};
            trial[i]   = shifted[i] - {1'b0, r_count};
            quo[i]     = r_neg[i] ? (~r_dq[i] + 1'b1) : r_dq[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= mul_a * mul_b;
        r_prod_term <= i_cmd.term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_last     <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_prev[i]  <= '0;
                r_cur[i]   <= '0;
                r_csum[i]  <= '0;
                r_cross[i] <= '0;
                r_dq[i]    <= '0;
                r_rem[i]   <= '0;
                r_neg[i]   <= 1'b0;
            end
        end else begin
            r_prod_vld <= i_cmd.mul_en;

            if (r_prod_vld) begin
                if (acc_sub) begin
                    r_cross[acc_idx] <= r_cross[acc_idx] - SUM_W'(r_prod);
                end else begin
                    r_cross[acc_idx] <= r_cross[acc_idx] + SUM_W'(r_prod);
                end
            end

            if (i_cmd.shift_prev) begin
                for (int i = 0; i < 3; i++) begin
                    r_prev[i] <= r_cur[i];
                end
            end

            if (i_cmd.div_start) begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_csum[i][CSUM_W-1];
                    r_dq[i]  <= r_csum[i][CSUM_W-1] ? (~r_csum[i] + 1'b1) : r_csum[i];
                    r_rem[i] <= '0;
                end
            end

            if (i_cmd.div_step) begin
                for (int i = 0; i < 3; i++) begin
                    if (!trial[i][CNT_W]) begin
                        r_rem[i] <= trial[i][CNT_W-1:0];
                    end else begin
                        r_rem[i] <= shifted[i][CNT_W-1:0];
                    end
                    r_dq[i] <= {r_dq[i][CSUM_W-2:0], ~trial[i][CNT_W]};
                end
            end

            if (i_cmd.accept) begin
                r_last <= i_last_point;
                for (int i = 0; i < 3; i++) begin
                    r_cur[i] <= pin[i];
                end
                priority if (count_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        r_first[i] <= pin[i];
                        r_prev[i]  <= pin[i];
                        r_csum[i]  <= CSUM_W'(pin[i]);
                        r_cross[i] <= '0;
                    end
                    r_ovf   <= 1'b0;
                    r_count <= CNT_W'(1);
                end else if (count_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_csum[i] <= r_csum[i] + CSUM_W'(pin[i]);
                    end
                    r_count <= r_count + 1'b1;
                end
            end

            if (i_cmd.clear) begin
                for (int i = 0; i < 3; i++) begin
                    r_first[i] <= '0;
                    r_prev[i]  <= '0;
                    r_csum[i]  <= '0;
                    r_cross[i] <= '0;
                end
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // result fields, valid while the result beat is shown
    assign o_area_x   = r_ovf ? '0 : r_cross[0][SUM_W-1:1];
    assign o_area_y   = r_ovf ? '0 : r_cross[1][SUM_W-1:1];
    assign o_area_z   = r_ovf ? '0 : r_cross[2][SUM_W-1:1];
    assign o_center_x = r_ovf ? '0 : quo[0][COORD_BITS-1:0];
    assign o_center_y = r_ovf ? '0 : quo[1][COORD_BITS-1:0];
    assign o_center_z = r_ovf ? '0 : quo[2][COORD_BITS-1:0];
    assign o_too_many_points = r_ovf;

endmodule

// ===== rtl/pvac_checker.sv =====
// ---------------------------------------------------------------------------
// pvac_checker
// port-level checks of the area unit, bound to the top level
// ---------------------------------------------------------------------------
`include "polygon_vector_area_centroid_unit_macros.svh"

module pvac_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  o_valid,
    input logic signed [pvac_pkg::AREA_W-1:0]     o_area_x,
    input logic signed [pvac_pkg::AREA_W-1:0]     o_area_y,
    input logic signed [pvac_pkg::AREA_W-1:0]     o_area_z,
    input logic signed [pvac_pkg::COORD_BITS-1:0] o_center_x,
    input logic                                  o_too_many_points
);
    import pvac_pkg::*;

    // result beat lasts a single cycle
    `PVAC_ASSERT(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe held")

    // the unit is free again right after a result beat
    `PVAC_ASSERT(a_valid_release, i_clk, i_rst_n, o_valid |=> !busy, "busy after result")

    // a result is only shown while the unit is occupied
    `PVAC_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy, "result while idle")

    // overflowed polygons report zero fields
    `PVAC_ASSERT(a_ovf_zero, i_clk, i_rst_n, (o_valid && o_too_many_points) |-> (o_area_x == '0 && o_area_y == '0 && o_area_z == '0 && o_center_x == '0), "overflow fields not zero")

    // reset returns the unit to idle
    `PVAC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_valid), "not idle after reset")

endmodule

bind polygon_vector_area_centroid_unit pvac_checker u_pvac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_area_x          (o_area_x),
    .o_area_y          (o_area_y),
    .o_area_z          (o_area_z),
    .o_center_x        (o_center_x),
    .o_too_many_points (o_too_many_points)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: polygon_vector_area_centroid_unit testbench
// streams polygon vertices into the unit through the start/busy handshake and
// predicts each vector area and vertex centroid in a scoreboard class. A short
// directed set covers coordinate extremes, single-vertex and degenerate
// polygons and the rounding of area and center. One long polygon crosses the
// vertex limit. Random polygons of mostly small size follow, with random sender
// gaps and drains.
// ---------------------------------------------------------------------------
module tb_top;
    import pvac_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_TAIL    = 50;
    localparam logic signed [COORD_BITS-1:0] CO_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] CO_MAX = ~CO_MIN;

    typedef struct {
        logic signed [AREA_W-1:0]     area_x;
        logic signed [AREA_W-1:0]     area_y;
        logic signed [AREA_W-1:0]     area_z;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic                         too_many_points;
    } t_polygon_result;

    class polygon_area_predictor;
        logic signed [COORD_BITS-1:0] first_v[3];
        logic signed [COORD_BITS-1:0] prev_v[3];
        logic signed [SUM_W-1:0]      cross_x, cross_y, cross_z;
        logic signed [CSUM_W-1:0]     coord_sum[3];
        int unsigned                  vertex_count;
        bit                           over_limit;
        t_polygon_result              awaited_areas[$];
        int                           mismatches;
        int                           vertices_seen;
        int                           polygons_seen;
        int                           single_vertex_polygons;
        int                           overflowed_polygons;

        function new();
            mismatches = 0;
            vertices_seen = 0;
            polygons_seen = 0;
            single_vertex_polygons = 0;
            overflowed_polygons = 0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            for (int i = 0; i < 3; i++) begin
                first_v[i] = '0;
                prev_v[i] = '0;
                coord_sum[i] = '0;
            end
            cross_x = '0;
            cross_y = '0;
            cross_z = '0;
            vertex_count = 0;
            over_limit = 1'b0;
        endfunction

        function void add_edge(input logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz);
            cross_x += SUM_W'(longint'(ay) * bz - longint'(az) * by);
            cross_y += SUM_W'(longint'(az) * bx - longint'(ax) * bz);
            cross_z += SUM_W'(longint'(ax) * by - longint'(ay) * bx);
        endfunction

        function int pending();
            return awaited_areas.size();
        endfunction

        // one accepted vertex beat
        function void take_vertex(input logic signed [COORD_BITS-1:0] x, y, z,
                                  input logic last);
            logic signed [COORD_BITS-1:0] p[3];
            t_polygon_result r;
            p[0] = x;
            p[1] = y;
            p[2] = z;
            vertices_seen++;
            if (vertex_count == 0) begin
                for (int i = 0; i < 3; i++) begin
                    first_v[i] = p[i];
                    prev_v[i] = p[i];
                    coord_sum[i] = p[i];
                end
                cross_x = '0;
                cross_y = '0;
                cross_z = '0;
                over_limit = 1'b0;
                vertex_count = 1;
            end else if (vertex_count >= MAX_POINTS) begin
                over_limit = 1'b1;
            end else begin
                add_edge(prev_v[0], prev_v[1], prev_v[2], p[0], p[1], p[2]);
                for (int i = 0; i < 3; i++) begin
                    coord_sum[i] += p[i];
                    prev_v[i] = p[i];
                end
                vertex_count++;
            end
            if (!last) return;
            polygons_seen++;
            if (over_limit) begin
                overflowed_polygons++;
                r.area_x = '0;
                r.area_y = '0;
                r.area_z = '0;
                r.center_x = '0;
                r.center_y = '0;
                r.center_z = '0;
                r.too_many_points = 1'b1;
            end else begin
                if (vertex_count == 1) single_vertex_polygons++;
                // closing edge back to the first vertex
                add_edge(prev_v[0], prev_v[1], prev_v[2], first_v[0], first_v[1], first_v[2]);
                r.area_x = AREA_W'(cross_x >>> 1);
                r.area_y = AREA_W'(cross_y >>> 1);
                r.area_z = AREA_W'(cross_z >>> 1);
                r.center_x = COORD_BITS'(longint'(coord_sum[0]) / longint'(vertex_count));
                r.center_y = COORD_BITS'(longint'(coord_sum[1]) / longint'(vertex_count));
                r.center_z = COORD_BITS'(longint'(coord_sum[2]) / longint'(vertex_count));
                r.too_many_points = 1'b0;
            end
            awaited_areas.insert(awaited_areas.size(), r);
            clear_polygon();
        endfunction

        function void note_mismatch(input string what, input longint expv, input longint gotv);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, actual %0d", what, expv, gotv);
        endfunction

        function void check_result(input t_polygon_result got);
            t_polygon_result exp_r;
            if (awaited_areas.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no polygon awaited: area %0d %0d %0d",
                             got.area_x, got.area_y, got.area_z);
                return;
            end
            exp_r = awaited_areas.pop_front();
            if (got.area_x !== exp_r.area_x) note_mismatch("area_x", exp_r.area_x, got.area_x);
            if (got.area_y !== exp_r.area_y) note_mismatch("area_y", exp_r.area_y, got.area_y);
            if (got.area_z !== exp_r.area_z) note_mismatch("area_z", exp_r.area_z, got.area_z);
            if (got.center_x !== exp_r.center_x)
                note_mismatch("center_x", exp_r.center_x, got.center_x);
            if (got.center_y !== exp_r.center_y)
                note_mismatch("center_y", exp_r.center_y, got.center_y);
            if (got.center_z !== exp_r.center_z)
                note_mismatch("center_z", exp_r.center_z, got.center_z);
            if (got.too_many_points !== exp_r.too_many_points)
                note_mismatch("too_many_points", exp_r.too_many_points, got.too_many_points);
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_point_x = '0;
    logic signed [COORD_BITS-1:0] i_point_y = '0;
    logic signed [COORD_BITS-1:0] i_point_z = '0;
    logic                         i_last_point = 1'b0;
    logic                         o_valid;
    logic signed [AREA_W-1:0]     o_area_x;
    logic signed [AREA_W-1:0]     o_area_y;
    logic signed [AREA_W-1:0]     o_area_z;
    logic signed [COORD_BITS-1:0] o_center_x;
    logic signed [COORD_BITS-1:0] o_center_y;
    logic signed [COORD_BITS-1:0] o_center_z;
    logic                         o_too_many_points;

    polygon_area_predictor sb;
    bit idle_on;
    int random_items;
    int quiet_cycles = 0;

    polygon_vector_area_centroid_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_point_z         (i_point_z),
        .i_last_point      (i_last_point),
        .o_valid           (o_valid),
        .o_area_x          (o_area_x),
        .o_area_y          (o_area_y),
        .o_area_z          (o_area_z),
        .o_center_x        (o_center_x),
        .o_center_y        (o_center_y),
        .o_center_z        (o_center_z),
        .o_too_many_points (o_too_many_points)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_polygon_result got;
        if (i_rst_n) begin
            if (start && !busy) sb.take_vertex(i_point_x, i_point_y, i_point_z, i_last_point);
            if (o_valid) begin
                got.area_x = o_area_x;
                got.area_y = o_area_y;
                got.area_z = o_area_z;
                got.center_x = o_center_x;
                got.center_y = o_center_y;
                got.center_z = o_center_z;
                got.too_many_points = o_too_many_points;
                sb.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("polygon_vector_area_centroid_unit verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_point(input logic signed [COORD_BITS-1:0] x, y, z, input logic last);
        start <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        i_last_point <= last;
        do @(posedge i_clk); while (busy);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return CO_MAX;
            1: return CO_MIN;
            2, 3: return COORD_BITS'($signed($urandom_range(0, 16)) - 8);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 4) return 1;
        if (sel < 14) return $urandom_range(2, 6);
        if (sel < 18) return $urandom_range(7, 20);
        return $urandom_range(21, 60);
    endfunction

    task automatic send_random_polygon(input int n);
        for (int k = 0; k < n; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
    endtask

    initial begin
        sb = new();
        idle_on = 1'b1;
        random_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single vertex polygons
        send_point(CO_MAX, CO_MIN, 0, 1'b1);
        send_point(CO_MIN, CO_MIN, CO_MIN, 1'b1);
        // two vertices, degenerate
        send_point(CO_MIN, CO_MAX, CO_MIN, 1'b0);
        send_point(CO_MAX, CO_MIN, CO_MAX, 1'b1);
        // extreme triangle and quad
        send_point(CO_MAX, CO_MIN, 0, 1'b0);
        send_point(CO_MIN, CO_MAX, CO_MAX, 1'b0);
        send_point(0, CO_MIN, CO_MAX, 1'b1);
        send_point(CO_MAX, CO_MAX, CO_MIN, 1'b0);
        send_point(CO_MIN, CO_MAX, CO_MAX, 1'b0);
        send_point(CO_MIN, CO_MIN, CO_MIN, 1'b0);
        send_point(CO_MAX, CO_MIN, CO_MAX, 1'b1);
        // odd cross sums, positive and negative
        send_point(0, 0, 0, 1'b0);
        send_point(1, 0, 0, 1'b0);
        send_point(0, 1, 0, 1'b1);
        send_point(0, 0, 0, 1'b0);
        send_point(0, 1, 0, 1'b0);
        send_point(1, 0, 0, 1'b1);
        // negative center truncates toward zero
        send_point(-1, 0, -3, 1'b0);
        send_point(0, 1, 4, 1'b1);
        drain_results();

        // vertex limit: several vertices past it
        send_random_polygon(MAX_POINTS + 7);
        drain_results();

        while (random_items < RANDOM_ITEMS) begin
            int n;
            n = pick_size();
            idle_on = (random_items < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 4) != 0);
            send_random_polygon(n);
            random_items += n;
            if (random_items < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 9) == 0)
                drain_results();
        end
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("covered %0d vertices in %0d polygons", sb.vertices_seen, sb.polygons_seen);
        $display("%0d single-vertex polygons, %0d past the vertex limit, %0d mismatches",
                 sb.single_vertex_polygons, sb.overflowed_polygons, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("polygon_vector_area_centroid_unit verification clean");
        end else begin
            $display("polygon_vector_area_centroid_unit verification failed");
        end
        $finish;
    end
endmodule
